// ===== hw/rtl/ialu_pkg.sv =====
// ----------------------------------------------------------------------------
// ialu_pkg - shared types and constants for the integer ALU
// Operand width, command codes, stream widths and the request/result words
// passed between the sequencer and the top level.
// ----------------------------------------------------------------------------
package ialu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int CMD_W      = 3;

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
  localparam logic [CMD_W-1:0] CMD_MOD = 3'd4;

  // largest positive value, +MAX; -MAX is its two's complement
  localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MAX_NEG = {1'b1, {(DATA_WIDTH-2){1'b0}}, 1'b1};

  typedef struct packed {
    logic [CMD_W-1:0]             command;
    logic signed [DATA_WIDTH-1:0] operand_a;
    logic signed [DATA_WIDTH-1:0] operand_b;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         zero_divisor;
    logic                         saturated;
  } res_t;

endpackage

// ===== hw/rtl/integer_alu_sat_mul_div_mod.sv =====
// ----------------------------------------------------------------------------
// integer_alu_sat_mul_div_mod - iterative integer ALU
// Add, subtract, saturating multiply, divide and modulo on signed words,
// all through one shared adder under a small sequencer.
// ----------------------------------------------------------------------------
// Multiply, divide and modulo step the adder once per operand bit before the
// result reaches the result register; add and subtract take a single step,
// unused commands and a zero divisor none. A new word is taken only once the
// sequencer is idle again, after its result has moved to the output register,
// so a new word can be taken while a result still waits in the output register.
// Reset: asynchronous, active low; clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module integer_alu_sat_mul_div_mod (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [ialu_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,  // operand_a, operand_b
  input  logic [ialu_pkg::CMD_W-1:0]          s_axis_tuser_i,  // command
  // result stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [ialu_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,  // value
  output logic [ialu_pkg::OUT_TUSER_W-1:0]    m_axis_tuser_o   // zero_divisor, saturated
);
  import ialu_pkg::*;

  req_t  req;
  res_t  core_res;
  res_t  out_q;
  logic  out_vld_q;
  logic  core_idle, core_done, start, load;

  assign req.command   = s_axis_tuser_i;
  assign req.operand_a = s_axis_tdata_i[DATA_WIDTH-1:0];
  assign req.operand_b = s_axis_tdata_i[2*DATA_WIDTH-1:DATA_WIDTH];

  // one word in flight in the sequencer
  assign s_axis_tready_o = core_idle;
  assign start           = s_axis_tvalid_i & core_idle;

  ialu_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .req_i   (req),
    .idle_o  (core_idle),
    .done_o  (core_done),
    .res_o   (core_res),
    .ack_i   (load)
  );

  // output register, refilled as it drains
  assign load = core_done & (~out_vld_q | m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= core_res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(unsigned'(out_q.value));
  assign m_axis_tuser_o  = {out_q.saturated, out_q.zero_divisor};

endmodule

// ===== hw/rtl/ialu_addsub.sv =====
// ----------------------------------------------------------------------------
// ialu_addsub - shared adder/subtractor
// One DATA_WIDTH+1 bit add or subtract with carry out; serves add, subtract,
// the shift-add multiply, the restoring divide and the final negation.
// ----------------------------------------------------------------------------
module ialu_addsub (
  input  logic [ialu_pkg::DATA_WIDTH:0]   x_i,
  input  logic [ialu_pkg::DATA_WIDTH:0]   y_i,
  input  logic                            sub_i,
  output logic [ialu_pkg::DATA_WIDTH+1:0] sum_o   // top bit: carry, set when no borrow
);
  import ialu_pkg::*;

  logic [DATA_WIDTH:0] y_inv;

  assign y_inv = sub_i ? ~y_i : y_i;
  assign sum_o = {1'b0, x_i} + {1'b0, y_inv} + {{(DATA_WIDTH+1){1'b0}}, sub_i};

endmodule

// ===== hw/rtl/ialu_core.sv =====
// ----------------------------------------------------------------------------
// ialu_core - sequencer around the shared adder
// Takes one request, steps the adder once per operand bit for multiply and
// nonzero divide/modulo (once for add/subtract), then presents the result.
// ----------------------------------------------------------------------------
module ialu_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  ialu_pkg::req_t   req_i,
  output logic             idle_o,
  output logic             done_o,
  output ialu_pkg::res_t   res_o,
  input  logic             ack_i
);
  import ialu_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic                  neg_q, neg_d;
  logic                  zdiv_q, zdiv_d;
  logic [DATA_WIDTH-1:0] hi_q, hi_d;
  logic [DATA_WIDTH-1:0] lo_q, lo_d;
  logic [DATA_WIDTH-1:0] mb_q, mb_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  logic [DATA_WIDTH-1:0] a_u, b_u, ma, mb;
  logic [DATA_WIDTH:0]   add_x, add_y, mul_s, div_t;
  logic                  add_sub;
  logic [DATA_WIDTH+1:0] add_sum;
  logic                  div_ge, mul_ovf;

  // magnitudes at intake; 2^(W-1) still fits unsigned
  assign a_u = req_i.operand_a;
  assign b_u = req_i.operand_b;
  assign ma  = a_u[DATA_WIDTH-1] ? (~a_u + 1'b1) : a_u;
  assign mb  = b_u[DATA_WIDTH-1] ? (~b_u + 1'b1) : b_u;

  ialu_addsub u_addsub (
    .x_i   (add_x),
    .y_i   (add_y),
    .sub_i (add_sub),
    .sum_o (add_sum)
  );

  // adder operand select
  always_comb begin
    add_x   = '0;
    add_y   = {1'b0, lo_q};
    add_sub = 1'b1;                 // idle/done: 0 - lo, the sign fix-up
    if (state_q == ST_RUN) begin
      case (cmd_q)
        CMD_MUL: begin
          add_x   = {1'b0, hi_q};
          add_y   = {1'b0, mb_q};
          add_sub = 1'b0;
        end
        CMD_DIV, CMD_MOD: begin
          add_x   = {hi_q, lo_q[DATA_WIDTH-1]};
          add_y   = {1'b0, mb_q};
          add_sub = 1'b1;
        end
        default: begin
          add_x   = {hi_q[DATA_WIDTH-1], hi_q};
          add_y   = {mb_q[DATA_WIDTH-1], mb_q};
          add_sub = (cmd_q == CMD_SUB);
        end
      endcase
    end
  end

  assign mul_s  = lo_q[0] ? add_sum[DATA_WIDTH:0] : {1'b0, hi_q};
  assign div_t  = {hi_q, lo_q[DATA_WIDTH-1]};
  assign div_ge = add_sum[DATA_WIDTH+1];

  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    neg_d   = neg_q;
    zdiv_d  = zdiv_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    mb_d    = mb_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_d  = req_i.command;
          neg_d  = a_u[DATA_WIDTH-1] ^ b_u[DATA_WIDTH-1];
          zdiv_d = 1'b0;
          hi_d   = '0;
          lo_d   = ma;
          mb_d   = mb;
          cnt_d  = CNT_W'(DATA_WIDTH - 1);
          case (req_i.command)
            CMD_ADD, CMD_SUB: begin
              hi_d    = a_u;
              mb_d    = b_u;
              cnt_d   = '0;
              state_d = ST_RUN;
            end
            CMD_MUL: state_d = ST_RUN;
            CMD_DIV, CMD_MOD: begin
              if (mb == '0) begin
                zdiv_d  = 1'b1;
                state_d = ST_DONE;
              end else begin
                state_d = ST_RUN;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_RUN: begin
        case (cmd_q)
          CMD_MUL: begin
            hi_d = mul_s[DATA_WIDTH:1];
            lo_d = {mul_s[0], lo_q[DATA_WIDTH-1:1]};
          end
          CMD_DIV, CMD_MOD: begin
            hi_d = div_ge ? add_sum[DATA_WIDTH-1:0] : div_t[DATA_WIDTH-1:0];
            lo_d = {lo_q[DATA_WIDTH-2:0], div_ge};
          end
          default: hi_d = add_sum[DATA_WIDTH-1:0];
        endcase
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    neg_q  <= neg_d;
    zdiv_q <= zdiv_d;
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    mb_q   <= mb_d;
    cnt_q  <= cnt_d;
  end

  // product above +MAX: any high bit, or the top low bit
  assign mul_ovf = (|hi_q) | lo_q[DATA_WIDTH-1];

  // result formatting; add_sum holds -lo here
  always_comb begin
    res_o = '0;
    case (cmd_q)
      CMD_ADD, CMD_SUB: res_o.value = hi_q;
      CMD_MUL: begin
        if (mul_ovf) begin
          res_o.saturated = 1'b1;
          res_o.value     = neg_q ? MAX_NEG : MAX_POS;
        end else begin
          res_o.value = neg_q ? add_sum[DATA_WIDTH-1:0] : lo_q;
        end
      end
      CMD_DIV: begin
        if (zdiv_q) begin
          res_o.zero_divisor = 1'b1;
          res_o.value        = MAX_POS;
        end else if (!neg_q && lo_q[DATA_WIDTH-1]) begin
          res_o.saturated = 1'b1;       // most negative over minus one
          res_o.value     = MAX_POS;
        end else begin
          res_o.value = neg_q ? add_sum[DATA_WIDTH-1:0] : lo_q;
        end
      end
      CMD_MOD: begin
        if (zdiv_q) begin
          res_o.zero_divisor = 1'b1;
          res_o.value        = MAX_POS;
        end else begin
          res_o.value = hi_q;
        end
      end
      default: res_o = '0;
    endcase
  end

  assign idle_o = (state_q == ST_IDLE);
  assign done_o = (state_q == ST_DONE);

  a_zdiv_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.zero_divisor) |-> (mb_q == '0))
    else $error("zero divisor flag without a zero divisor");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(res_o.zero_divisor && res_o.saturated))
    else $error("both flags raised");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && cnt_q == '0) |=> (state_q == ST_DONE))
    else $error("sequencer overran its step count");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && cmd_q == CMD_MOD && !zdiv_q) |-> (hi_q < mb_q))
    else $error("remainder not below divisor");

endmodule
